[hdl/lhik_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhik_pkg
// Shared types, widths and constants of the leg height IK sweep.
// ----------------------------------------------------------------------------
package lhik_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ANGLE_FRAC_DEF    = 8;

    localparam int LEN_W  = 10;   // segment lengths and height
    localparam int DEG_W  = 9;    // limit registers in degrees
    localparam int XW     = 34;   // CORDIC x/y, Q30
    localparam int ZW     = 32;   // CORDIC angle, degrees in Q20
    localparam int REM_W  = 46;   // numerator of s, Q30
    localparam int MAG_W  = 45;   // numerator magnitude
    localparam int S_W    = 32;   // s in Q30
    localparam int SQ_W   = 61;   // radicand of the square root
    localparam int ROOT_W = 31;   // square root result, Q30
    localparam int ROOT_STEPS = 31;

    localparam logic signed [XW-1:0] CORDIC_K   = 34'sd652032875;
    localparam logic signed [ZW-1:0] DEG90_Q20  = 32'sd94371840;
    localparam logic signed [ZW-1:0] DEG180_Q20 = 32'sd188743680;
    localparam logic [MAG_W-1:0]     Q30_ONE    = 45'h0000_4000_0000;
    localparam logic [SQ_W-1:0]      Q60_ONE    = 61'h1000_0000_0000_0000;

    localparam int FALLBACK_FEMUR_DEG = 30;
    localparam int FALLBACK_TIBIA_DEG = 20;

    localparam logic [2:0] REG_COXA  = 3'd0;
    localparam logic [2:0] REG_FEMUR = 3'd1;
    localparam logic [2:0] REG_TIBIA = 3'd2;
    localparam logic [2:0] REG_FMIN  = 3'd3;
    localparam logic [2:0] REG_FMAX  = 3'd4;
    localparam logic [2:0] REG_TMIN  = 3'd5;
    localparam logic [2:0] REG_TMAX  = 3'd6;

    typedef struct packed {
        logic start;
        logic vec;      // 1: vectoring (asin), 0: rotation (sin)
    } t_cordic_cmd;

    // atan(2^-i) in degrees, Q20
    function automatic logic signed [ZW-1:0] lhik_atan(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0:  v = 32'sd47185920;
            5'd1:  v = 32'sd27855475;
            5'd2:  v = 32'sd14718068;
            5'd3:  v = 32'sd7471121;
            5'd4:  v = 32'sd3750058;
            5'd5:  v = 32'sd1876857;
            5'd6:  v = 32'sd938658;
            5'd7:  v = 32'sd469357;
            5'd8:  v = 32'sd234682;
            5'd9:  v = 32'sd117342;
            5'd10: v = 32'sd58671;
            5'd11: v = 32'sd29335;
            5'd12: v = 32'sd14668;
            5'd13: v = 32'sd7334;
            5'd14: v = 32'sd3667;
            5'd15: v = 32'sd1833;
            5'd16: v = 32'sd917;
            5'd17: v = 32'sd458;
            5'd18: v = 32'sd229;
            5'd19: v = 32'sd115;
            5'd20: v = 32'sd57;
            5'd21: v = 32'sd29;
            5'd22: v = 32'sd14;
            5'd23: v = 32'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[hdl/lhik_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhik_cordic
// Shared CORDIC unit, one micro-rotation per cycle, rotation or vectoring.
// ----------------------------------------------------------------------------
module lhik_cordic #(
    parameter int CORDIC_STAGES = lhik_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lhik_pkg::t_cordic_cmd             i_cmd,
    input  logic signed [lhik_pkg::XW-1:0]    i_x0,
    input  logic signed [lhik_pkg::XW-1:0]    i_y0,
    input  logic signed [lhik_pkg::ZW-1:0]    i_z0,
    output logic                              o_done,
    output logic signed [lhik_pkg::XW-1:0]    o_y,
    output logic signed [lhik_pkg::ZW-1:0]    o_z
);
    import lhik_pkg::*;

    localparam int IDX_W = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;

    logic signed [XW-1:0] r_x, r_y, n_x, n_y, w_dx, w_dy;
    logic signed [ZW-1:0] r_z, n_z, w_at;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_vec, r_busy, r_done, w_up;

    always_comb begin
        w_dx = r_y >>> r_idx;
        w_dy = r_x >>> r_idx;
        w_at = lhik_atan(5'(r_idx));
        w_up = r_vec ? r_y[XW-1] : ~r_z[ZW-1];
        if (w_up) begin
            n_x = r_x - w_dx;
            n_y = r_y + w_dy;
            n_z = r_z - w_at;
        end else begin
            n_x = r_x + w_dx;
            n_y = r_y - w_dy;
            n_z = r_z + w_at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (r_busy) begin
                r_idx <= r_idx + 1'b1;
                if (r_idx == IDX_W'(CORDIC_STAGES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_x   <= i_x0;
            r_y   <= i_y0;
            r_z   <= i_z0;
            r_vec <= i_cmd.vec;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_done = r_done;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

[hdl/lhik_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhik_div
// Restoring divider of a magnitude by the coxa length, one bit per cycle.
// ----------------------------------------------------------------------------
module lhik_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lhik_pkg::MAG_W-1:0]    i_num,
    input  logic [lhik_pkg::LEN_W-1:0]    i_den,
    output logic                          o_done,
    output logic [lhik_pkg::MAG_W-1:0]    o_quo
);
    import lhik_pkg::*;

    localparam int CNT_W = $clog2(MAG_W + 1);

    logic [MAG_W-1:0] r_q;
    logic [LEN_W-1:0] r_rem;
    logic [LEN_W:0]   w_trial;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done, w_ge;

    assign w_trial = {r_rem, r_q[MAG_W-1]};
    assign w_ge    = w_trial >= {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MAG_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[MAG_W-2:0], w_ge};
            r_rem <= w_ge ? LEN_W'(w_trial - {1'b0, i_den}) : LEN_W'(w_trial);
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

[hdl/lhik_isqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhik_isqrt
// Integer floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module lhik_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lhik_pkg::SQ_W-1:0]     i_rad,
    output logic                          o_done,
    output logic [lhik_pkg::ROOT_W-1:0]   o_root
);
    import lhik_pkg::*;

    localparam int CNT_W = $clog2(ROOT_STEPS + 1);

    logic [SQ_W-1:0]  r_n, r_r, r_bit, w_sum;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done, w_ge;

    assign w_sum = r_r + r_bit;
    assign w_ge  = r_n >= w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ROOT_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_rad;
            r_r   <= '0;
            r_bit <= Q60_ONE;
        end else if (r_busy) begin
            if (w_ge) begin
                r_n <= r_n - w_sum;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[ROOT_W-1:0];

endmodule

[hdl/leg_height_ik_sweep.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leg_height_ik_sweep
// Tibia-angle sweep that finds femur/tibia angles for a target body height.
// ----------------------------------------------------------------------------
// One request carries a target height. The block sweeps beta over the tibia
// limits in half-degree steps; each step runs a CORDIC sine, one multiply,
// a bit-serial divide by the coxa length, a square, a bit-serial square root
// and a CORDIC arcsine. Steps whose |s| exceeds one end after the divide.
// The input is not ready during a sweep; one finished result waits in the
// output register while the next request is taken.
module leg_height_ik_sweep #(
    parameter int CORDIC_STAGES   = lhik_pkg::CORDIC_STAGES_DEF,
    parameter int ANGLE_FRAC_BITS = lhik_pkg::ANGLE_FRAC_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [9:0] target_height
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [15:0] alpha, [32:16] beta
    output logic        m_axis_tuser,   // solution_found
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lhik_pkg::*;

    localparam int B_W  = 10 + ANGLE_FRAC_BITS;
    localparam int C_W  = B_W + 2;
    localparam int SH   = 20 - ANGLE_FRAC_BITS;
    localparam logic signed [ZW-1:0]  RND_Q20 = ZW'(1) <<< (SH - 1);
    localparam logic signed [B_W-1:0] HALF    = B_W'(1) <<< (ANGLE_FRAC_BITS - 1);
    localparam logic signed [B_W-1:0] FB_A    = B_W'(FALLBACK_FEMUR_DEG) <<< ANGLE_FRAC_BITS;
    localparam logic signed [B_W-1:0] FB_B    = B_W'(FALLBACK_TIBIA_DEG) <<< ANGLE_FRAC_BITS;

    typedef enum logic [13:0] {
        ST_IDLE    = 14'b00000000000001,
        ST_SIN_GO  = 14'b00000000000010,
        ST_SIN     = 14'b00000000000100,
        ST_MUL     = 14'b00000000001000,
        ST_DIV_GO  = 14'b00000000010000,
        ST_DIV     = 14'b00000000100000,
        ST_SQ      = 14'b00000001000000,
        ST_SQRT_GO = 14'b00000010000000,
        ST_SQRT    = 14'b00000100000000,
        ST_ASIN_GO = 14'b00001000000000,
        ST_ASIN    = 14'b00010000000000,
        ST_EVAL    = 14'b00100000000000,
        ST_NEXT    = 14'b01000000000000,
        ST_DONE    = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [LEN_W-1:0] r_coxa, r_femur, r_tibia;
    logic [DEG_W-1:0] r_fmin, r_fmax, r_tmin, r_tmax;
    logic             w_wr;

    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coxa  <= 10'd50;
            r_femur <= 10'd101;
            r_tibia <= 10'd208;
            r_fmin  <= -9'sd90;
            r_fmax  <= 9'sd90;
            r_tmin  <= -9'sd90;
            r_tmax  <= 9'sd90;
        end else if (w_wr) begin
            unique case (paddr[4:2])
                REG_COXA:  r_coxa  <= pwdata[LEN_W-1:0];
                REG_FEMUR: r_femur <= pwdata[LEN_W-1:0];
                REG_TIBIA: r_tibia <= pwdata[LEN_W-1:0];
                REG_FMIN:  r_fmin  <= pwdata[DEG_W-1:0];
                REG_FMAX:  r_fmax  <= pwdata[DEG_W-1:0];
                REG_TMIN:  r_tmin  <= pwdata[DEG_W-1:0];
                REG_TMAX:  r_tmax  <= pwdata[DEG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_COXA:  prdata = 32'(r_coxa);
            REG_FEMUR: prdata = 32'(r_femur);
            REG_TIBIA: prdata = 32'(r_tibia);
            REG_FMIN:  prdata = 32'(r_fmin);
            REG_FMAX:  prdata = 32'(r_fmax);
            REG_TMIN:  prdata = 32'(r_tmin);
            REG_TMAX:  prdata = 32'(r_tmax);
            default:   prdata = '0;
        endcase
    end

    // shared units
    t_cordic_cmd          w_ccmd;
    logic signed [XW-1:0] w_cx0, w_cy0, w_cy;
    logic signed [ZW-1:0] w_cz0, w_cz, w_bq;
    logic                 w_cdone, w_ddone, w_qdone;
    logic [MAG_W-1:0]     w_rem_mag, w_quo;
    logic [ROOT_W-1:0]    w_root;

    // sweep datapath
    logic signed [REM_W-1:0]       r_base, r_rem;
    logic signed [XW-1:0]          r_sin;
    logic signed [XW+LEN_W:0]      w_prod;
    logic signed [S_W-1:0]         r_s;
    logic signed [2*S_W-1:0]       w_sq;
    logic [SQ_W-1:0]               r_rad;
    logic [ROOT_W-1:0]             r_root;
    logic signed [ZW-1:0]          r_z_hold;
    logic signed [B_W-1:0]         r_b, w_bstart, w_bend, w_bnext;
    logic signed [B_W-1:0]         r_best_a, r_best_b;
    logic [C_W-1:0]                r_best_score;
    logic                          r_found;
    logic signed [LEN_W:0]         w_hdiff;
    logic signed [ZW-1:0]          w_a_q;
    logic signed [C_W-1:0]         w_a, w_bw, w_rel, w_amin, w_amax;
    logic [C_W-1:0]                w_score;
    logic                          w_pass, w_acc;

    // output register
    logic                r_ovalid, r_ofound;
    logic signed [15:0]  r_ofa;
    logic signed [16:0]  r_ota;

    assign w_acc         = s_axis_tvalid & s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_hdiff       = $signed({1'b0, s_axis_tdata[LEN_W-1:0]}) - $signed({1'b0, r_tibia});
    assign w_bstart      = B_W'($signed(r_tmin)) <<< ANGLE_FRAC_BITS;
    assign w_bend        = B_W'($signed(r_tmax)) <<< ANGLE_FRAC_BITS;
    assign w_bnext       = r_b + HALF;
    assign w_prod        = $signed({1'b0, r_femur}) * r_sin;
    assign w_sq          = r_s * r_s;
    assign w_rem_mag     = r_rem[REM_W-1] ? MAG_W'(-r_rem) : MAG_W'(r_rem);

    // fold beta into [-90, 90] degrees before the sine
    always_comb begin
        w_bq = ZW'(r_b) <<< SH;
        if (w_bq > DEG90_Q20) begin
            w_cz0 = DEG180_Q20 - w_bq;
        end else if (w_bq < -DEG90_Q20) begin
            w_cz0 = -DEG180_Q20 - w_bq;
        end else begin
            w_cz0 = w_bq;
        end
        w_ccmd.start = (r_state == ST_SIN_GO) || (r_state == ST_ASIN_GO);
        w_ccmd.vec   = (r_state == ST_ASIN_GO);
        w_cx0 = w_ccmd.vec ? XW'(r_root) : CORDIC_K;
        w_cy0 = w_ccmd.vec ? XW'(r_s) : '0;
        if (w_ccmd.vec) begin
            w_cz0 = '0;
        end
    end

    // limit checks and score on the rounded alpha
    always_comb begin
        w_a_q   = (r_z_hold + RND_Q20) >>> SH;
        w_a     = C_W'(w_a_q);
        w_bw    = C_W'(r_b);
        w_rel   = w_bw - w_a;
        w_amin  = C_W'($signed(r_fmin)) <<< ANGLE_FRAC_BITS;
        w_amax  = C_W'($signed(r_fmax)) <<< ANGLE_FRAC_BITS;
        w_pass  = (w_a >= w_amin) && (w_a <= w_amax) &&
                  (w_rel >= w_amin) && (w_rel <= w_amax);
        w_score = C_W'((w_a[C_W-1] ? -w_a : w_a) + (w_bw[C_W-1] ? -w_bw : w_bw));
    end

    lhik_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_ccmd),
        .i_x0    (w_cx0),
        .i_y0    (w_cy0),
        .i_z0    (w_cz0),
        .o_done  (w_cdone),
        .o_y     (w_cy),
        .o_z     (w_cz)
    );

    lhik_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_DIV_GO),
        .i_num   (w_rem_mag),
        .i_den   (r_coxa),
        .o_done  (w_ddone),
        .o_quo   (w_quo)
    );

    lhik_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_SQRT_GO),
        .i_rad   (r_rad),
        .o_done  (w_qdone),
        .o_root  (w_root)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (w_acc) begin
                            n_state = ((r_coxa == '0) || (w_bstart > w_bend)) ? ST_DONE
                                                                               : ST_SIN_GO;
                        end
            ST_SIN_GO:  n_state = ST_SIN;
            ST_SIN:     if (w_cdone) n_state = ST_MUL;
            ST_MUL:     n_state = ST_DIV_GO;
            ST_DIV_GO:  n_state = ST_DIV;
            ST_DIV:     if (w_ddone) n_state = (w_quo > Q30_ONE) ? ST_NEXT : ST_SQ;
            ST_SQ:      n_state = ST_SQRT_GO;
            ST_SQRT_GO: n_state = ST_SQRT;
            ST_SQRT:    if (w_qdone) n_state = ST_ASIN_GO;
            ST_ASIN_GO: n_state = ST_ASIN;
            ST_ASIN:    if (w_cdone) n_state = ST_EVAL;
            ST_EVAL:    n_state = ST_NEXT;
            ST_NEXT:    n_state = (w_bnext > w_bend) ? ST_DONE : ST_SIN_GO;
            ST_DONE:    if (!r_ovalid || m_axis_tready) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE && w_acc) begin
                r_found <= 1'b0;
            end else if (r_state == ST_EVAL && w_pass &&
                         (!r_found || w_score < r_best_score)) begin
                r_found <= 1'b1;
            end
            if (r_state == ST_DONE && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_base   <= REM_W'(w_hdiff) <<< 30;
                r_b      <= w_bstart;
                r_best_a <= FB_A;
                r_best_b <= FB_B;
            end
            ST_SIN:  if (w_cdone) r_sin <= w_cy;
            ST_MUL:  r_rem <= r_base - REM_W'(w_prod);
            ST_DIV: begin
                if (w_ddone) begin
                    r_s <= r_rem[REM_W-1] ? -S_W'(w_quo) : S_W'(w_quo);
                end
            end
            ST_SQ:   r_rad <= Q60_ONE - SQ_W'(w_sq);
            ST_SQRT: if (w_qdone) r_root <= w_root;
            ST_ASIN: if (w_cdone) r_z_hold <= w_cz;
            ST_EVAL: begin
                if (w_pass && (!r_found || w_score < r_best_score)) begin
                    r_best_score <= w_score;
                    r_best_a     <= B_W'(w_a);
                    r_best_b     <= r_b;
                end
            end
            ST_NEXT: r_b <= w_bnext;
            ST_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    r_ofa    <= 16'(r_best_a);
                    r_ota    <= 17'(r_best_b);
                    r_ofound <= r_found;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'd0, r_ota, r_ofa};
    assign m_axis_tuser  = r_ofound;

endmodule

[hdl/lhik_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhik_checker
// Port-level checks of the leg height IK sweep, bound to the top level.
// ----------------------------------------------------------------------------
module lhik_checker #(
    parameter int ANGLE_FRAC_BITS = lhik_pkg::ANGLE_FRAC_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    import lhik_pkg::*;

    localparam logic [15:0] FB_A = 16'(FALLBACK_FEMUR_DEG << ANGLE_FRAC_BITS);
    localparam logic [16:0] FB_B = 17'(FALLBACK_TIBIA_DEG << ANGLE_FRAC_BITS);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // drop ready once a request starts a sweep
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready during sweep");

    // fallback result carries the fixed angles
    a_fallback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            m_axis_tdata[15:0] == FB_A && m_axis_tdata[32:16] == FB_B)
        else $error("fallback angles wrong");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind leg_height_ik_sweep lhik_checker #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lhik_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[tb/leg_height_ik_sweep_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leg_height_ik_sweep_test
// Self-checking bench for the leg height IK sweep.
// ----------------------------------------------------------------------------
// A table of directed heights and register settings runs first: the reset
// setting, the fallback cases and the extremes of the lengths, the limits and
// the height. Random phases follow. Each phase writes a fresh register setting
// over APB while the block is idle, then sends bursts of random heights. Every
// phase uses narrow tibia ranges so that each sweep stays short. Every accepted
// request is run through a bit-exact model of the sweep, and every result is
// checked in order against it. Traffic is bursty on the input side, and the
// output side stalls on a pattern of its own, with one long hold-off.
// ----------------------------------------------------------------------------
module leg_height_ik_sweep_test;
    import lhik_pkg::*;

    typedef struct {
        logic [15:0] femur;
        logic [16:0] tibia;
        logic        found;
    } t_angles;

    typedef struct packed {
        int coxa; int femur; int tib; int fmin; int fmax; int tmin; int tmax;
        int height;
        bit known;
        int exp_femur; int exp_tibia;
        bit exp_found;
    } t_row;

    localparam longint UNIT = 256;
    localparam longint HALF_STEP = 128;
    localparam longint TO_Q20 = 4096;
    localparam longint ROUND_Q20 = 2048;
    localparam longint ONE_Q30 = 64'sd1 << 30;
    localparam int N_ROWS = 13;
    localparam int FB_FEMUR = FALLBACK_FEMUR_DEG * 256;
    localparam int FB_TIBIA = FALLBACK_TIBIA_DEG * 256;
    localparam int REG_UNUSED = 7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // register shadow
    logic [9:0] coxa_len, femur_len, tibia_len;
    logic [8:0] femur_lo, femur_hi, tibia_lo, tibia_hi;

    t_angles pending_angles[$];
    int      errors = 0;
    int      hold_cycles = 0;
    int      burst_left = 0;
    t_row    dir_rows [N_ROWS];

    leg_height_ik_sweep dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic longint sin_q30(longint b);
        longint x, y, z, dx, dy;
        x = CORDIC_K;
        y = 0;
        z = b;
        if (b > 90 * 64'sd1048576) z = 180 * 64'sd1048576 - b;
        else if (b < -90 * 64'sd1048576) z = -180 * 64'sd1048576 - b;
        for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= lhik_atan(i[4:0]);
            end else begin
                x += dx; y -= dy; z += lhik_atan(i[4:0]);
            end
        end
        return y;
    endfunction

    function automatic longint floor_sqrt(longint unsigned n);
        longint unsigned r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= r + bitv) begin
                n -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint asin_q20(longint s);
        longint x, y, z, dx, dy;
        x = floor_sqrt((64'd1 << 60) - longint'(s * s));
        y = s;
        z = 0;
        for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += lhik_atan(i[4:0]);
            end else begin
                x -= dx; y += dy; z -= lhik_atan(i[4:0]);
            end
        end
        return z;
    endfunction

    function automatic t_angles solve_leg(logic [9:0] height);
        longint base, amin, amax, bend, b, rem, s, a, rel, score;
        longint best_a, best_b, best_score;
        bit found;
        t_angles res;
        base = (longint'(height) - longint'(tibia_len)) * ONE_Q30;
        amin = longint'($signed(femur_lo)) * UNIT;
        amax = longint'($signed(femur_hi)) * UNIT;
        bend = longint'($signed(tibia_hi)) * UNIT;
        best_a = 30 * UNIT;
        best_b = 20 * UNIT;
        best_score = 0;
        found = 0;
        for (b = longint'($signed(tibia_lo)) * UNIT; b <= bend && coxa_len != 0;
             b += HALF_STEP) begin
            rem = base - longint'(femur_len) * sin_q30(b * TO_Q20);
            s = rem / longint'(coxa_len);
            if (s > ONE_Q30 || s < -ONE_Q30) continue;
            a = (asin_q20(s) + ROUND_Q20) >>> 12;
            if (a < amin || a > amax) continue;
            rel = b - a;
            if (rel < amin || rel > amax) continue;
            score = (a < 0 ? -a : a) + (b < 0 ? -b : b);
            if (!found || score < best_score) begin
                found = 1;
                best_score = score;
                best_a = a;
                best_b = b;
            end
        end
        res.femur = best_a[15:0];
        res.tibia = best_b[16:0];
        res.found = found;
        return res;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // predict each accepted request, check each accepted result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                pending_angles.push_back(solve_leg(s_axis_tdata[9:0]));
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_angles.size() == 0) begin
                    report("unexpected result", m_axis_tdata[15:0], 0);
                end else begin
                    t_angles want;
                    want = pending_angles.pop_front();
                    if (m_axis_tdata[15:0] !== want.femur)
                        report("alpha", $signed(m_axis_tdata[15:0]),
                               $signed(want.femur));
                    if (m_axis_tdata[32:16] !== want.tibia)
                        report("beta", $signed(m_axis_tdata[32:16]),
                               $signed(want.tibia));
                    if (m_axis_tuser !== want.found)
                        report("solution_found", m_axis_tuser, want.found);
                end
            end
        end
    end

    // receiver: stall pattern in stretches, plus requested hold-offs
    int stretch = 0;
    int rx_mode = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            m_axis_tready <= 1'b0;
            hold_cycles--;
        end else begin
            if (stretch == 0) begin
                stretch = $urandom_range(1, 40);
                rx_mode = $urandom_range(0, 2);
            end
            stretch--;
            m_axis_tready <= (rx_mode == 0) ? 1'b1 : ($urandom_range(0, rx_mode) == 0);
        end
    end

    task automatic reg_write(int idx, int value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(idx * 4);
        pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_COXA:  coxa_len  = 10'(value);
            REG_FEMUR: femur_len = 10'(value);
            REG_TIBIA: tibia_len = 10'(value);
            REG_FMIN:  femur_lo  = 9'(value);
            REG_FMAX:  femur_hi  = 9'(value);
            REG_TMIN:  tibia_lo  = 9'(value);
            REG_TMAX:  tibia_hi  = 9'(value);
            default: ;
        endcase
    endtask

    // wait for the request accepted at the last edge to be queued first
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_angles.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic load_setting(int c, int f, int t, int fmn, int fmx, int tmn, int tmx);
        drain();
        reg_write(REG_COXA, c);
        reg_write(REG_FEMUR, f);
        reg_write(REG_TIBIA, t);
        reg_write(REG_FMIN, fmn);
        reg_write(REG_FMAX, fmx);
        reg_write(REG_TMIN, tmn);
        reg_write(REG_TMAX, tmx);
    endtask

    // hold valid across back-to-back requests; drop it only for a real gap
    task automatic send_height(logic [9:0] h);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 6);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'b0, h};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    initial begin
        int tmn, tmx, fmn, fmx;
        coxa_len = 10'd50; femur_len = 10'd101; tibia_len = 10'd208;
        femur_lo = -9'sd90; femur_hi = 9'sd90; tibia_lo = -9'sd90; tibia_hi = 9'sd90;
        dir_rows = '{
            '{50, 101, 208, -90, 90, -90, 90, 250, 0, 0, 0, 0},
            '{0, 101, 208, -90, 90, -10, 10, 300, 1, FB_FEMUR, FB_TIBIA, 0},
            '{50, 101, 208, -90, 90, 10, -10, 300, 1, FB_FEMUR, FB_TIBIA, 0},
            '{50, 101, 208, 40, -40, -5, 5, 300, 1, FB_FEMUR, FB_TIBIA, 0},
            '{50, 101, 208, -90, 90, -5, 5, 0, 0, 0, 0, 0},
            '{50, 101, 208, -90, 90, -5, 5, 1023, 0, 0, 0, 0},
            '{1, 101, 208, -90, 90, -3, 3, 260, 0, 0, 0, 0},
            '{1023, 1023, 1023, -180, 180, -180, -177, 1023, 0, 0, 0, 0},
            '{50, 0, 0, -180, 180, 177, 180, 20, 0, 0, 0, 0},
            '{1023, 1023, 0, -180, 180, 0, 3, 512, 0, 0, 0, 0},
            '{50, 101, 208, -90, 90, -2, 2, 308, 0, 0, 0, 0},
            '{1023, 0, 0, -180, 180, 88, 90, 1023, 0, 0, 0, 0},
            '{60, 120, 150, -60, 60, 45, 45, 200, 0, 0, 0, 0}
        };
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first request runs on the reset setting
        send_height(10'(dir_rows[0].height));
        drain();
        reg_write(REG_UNUSED, 12345);   // unused index, must be ignored
        for (int r = 0; r < N_ROWS; r++) begin
            load_setting(dir_rows[r].coxa, dir_rows[r].femur, dir_rows[r].tib,
                         dir_rows[r].fmin, dir_rows[r].fmax,
                         dir_rows[r].tmin, dir_rows[r].tmax);
            send_height(10'(dir_rows[r].height));
            if (dir_rows[r].known) begin
                drain();
                if (m_axis_tdata[15:0] !== 16'(dir_rows[r].exp_femur) ||
                    m_axis_tdata[32:16] !== 17'(dir_rows[r].exp_tibia) ||
                    m_axis_tuser !== dir_rows[r].exp_found)
                    report("fallback row", r, dir_rows[r].exp_femur);
            end
        end

        for (int ph = 0; ph < 5; ph++) begin
            tmn = $urandom_range(0, 358) - 180;
            tmx = tmn + $urandom_range(0, 4);
            if (tmx > 180) tmx = 180;
            if ($urandom_range(0, 9) == 0) tmx = tmn - 1;
            fmn = $urandom_range(0, 180) - 180;
            fmx = $urandom_range(0, 180);
            if ($urandom_range(0, 9) == 0) fmx = fmn - 1;
            load_setting($urandom_range(1, 1023), $urandom_range(0, 1023),
                         $urandom_range(0, 1023), fmn, fmx, tmn, tmx);
            for (int k = 0; k < 20; k++) begin
                if (ph == 1 && k == 5) hold_cycles = 3000;
                if (ph == 3 && k == 10) drain();
                // heights near tibia_len give solvable sweeps more often
                if ($urandom_range(0, 2) != 0)
                    send_height(10'(tibia_len + coxa_len / 2 + $urandom_range(0, 200)));
                else
                    send_height(10'($urandom_range(0, 1023)));
            end
        end

        drain();
        repeat (200) @(posedge i_clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
hdl/lhik_pkg.sv
hdl/lhik_cordic.sv
hdl/lhik_div.sv
hdl/lhik_isqrt.sv
hdl/leg_height_ik_sweep.sv
hdl/lhik_checker.sv
tb/leg_height_ik_sweep_test.sv
